FILE: sv/mfpr_pkg.sv
package mfpr_pkg;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Event numbers
  localparam logic [2:0] EV_TIMER_C = 3'd5;
  localparam logic [2:0] EV_GPIP    = 3'd6;

  // Register window
  localparam logic [31:0] MFP_BASE = 32'h00ff_fa00;
  localparam logic [31:0] MFP_LAST = 32'h0000_002f;

  // Register offsets
  localparam logic [5:0] OFF_GPIP     = 6'h01;
  localparam logic [5:0] OFF_EDGE     = 6'h03;
  localparam logic [5:0] OFF_DIR      = 6'h05;
  localparam logic [5:0] OFF_IEN_HI   = 6'h07;
  localparam logic [5:0] OFF_IEN_LO   = 6'h09;
  localparam logic [5:0] OFF_IPEND_HI = 6'h0b;
  localparam logic [5:0] OFF_IPEND_LO = 6'h0d;
  localparam logic [5:0] OFF_ISRV_HI  = 6'h0f;
  localparam logic [5:0] OFF_ISRV_LO  = 6'h11;
  localparam logic [5:0] OFF_IMSK_HI  = 6'h13;
  localparam logic [5:0] OFF_IMSK_LO  = 6'h15;
  localparam logic [5:0] OFF_VECTOR   = 6'h17;
  localparam logic [5:0] OFF_TACR     = 6'h19;
  localparam logic [5:0] OFF_TBCR     = 6'h1b;
  localparam logic [5:0] OFF_TCDCR    = 6'h1d;
  localparam logic [5:0] OFF_TADR     = 6'h1f;
  localparam logic [5:0] OFF_TBDR     = 6'h21;
  localparam logic [5:0] OFF_TCDR     = 6'h23;
  localparam logic [5:0] OFF_TDDR     = 6'h25;

  localparam logic [7:0] IPEND_HI_READ = 8'h20;
  localparam logic [7:0] VECTOR_AEOI   = 8'h48;
  localparam logic [7:0] VECTOR_BASE   = 8'h40;

  localparam int NUM_TIMERS = 4;
  localparam logic [1:0] TMR_A = 2'd0;
  localparam logic [1:0] TMR_B = 2'd1;
  localparam logic [1:0] TMR_C = 2'd2;
  localparam logic [1:0] TMR_D = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [7:0]  write_data;
    logic [2:0]  irq_number;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
    logic       gpip_irq;
  } rsp_t;

  typedef struct packed {
    logic       ctrl_we;
    logic       flag_clr;
    logic [3:0] mode;
    logic       data_we;
    logic [7:0] data;
    logic       read;
    logic       tick;
  } tmr_cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       flag;
    logic [7:0] count_rd;
    logic       fire;
  } tmr_stat_t;

endpackage

FILE: sv/mfpr_timer.sv
module mfpr_timer (
  input  logic                clk,
  input  logic                rst,
  input  mfpr_pkg::tmr_cmd_t  cmd,
  output mfpr_pkg::tmr_stat_t stat
);
  import mfpr_pkg::*;

  logic [3:0] mode;
  logic       flag;
  logic [7:0] reload;
  logic [7:0] count;

  logic running;
  logic dec_rd;
  logic hold;

  // Running timers count down on a data read while above two
  assign running = (mode != 4'd0);
  assign dec_rd  = running && (count > 8'd2);
  // A tick at the reload value steps once before expiring
  assign hold    = (count == reload) && (count > 8'd1);

  assign stat.mode     = mode;
  assign stat.flag     = flag;
  assign stat.count_rd = dec_rd ? count - 8'd1 : count;
  assign stat.fire     = cmd.tick && running && !hold;

  // Update control, reload and count
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 4'd0;
      flag   <= 1'b0;
      reload <= 8'd0;
      count  <= 8'd0;
    end else begin
      if (cmd.ctrl_we) begin
        mode <= cmd.mode;
        if (cmd.flag_clr) begin
          flag <= 1'b0;
        end
      end
      if (cmd.data_we) begin
        reload <= cmd.data;
        if (!running) begin
          count <= cmd.data;
        end
      end
      if (cmd.read && dec_rd) begin
        count <= count - 8'd1;
      end
      if (cmd.tick && running) begin
        if (hold) begin
          count <= count - 8'd1;
        end else begin
          flag  <= 1'b1;
          count <= reload;
        end
      end
    end
  end

endmodule

FILE: sv/multifunction_peripheral_registers_top.sv
// Byte register file of a simplified multifunction peripheral at 0xfffa00.
// Request channel (req_valid, req_stall, req): each word is a bus read, a
// bus write, or an interrupt event (event 5 ticks timer C, event 6 clears
// GPIP bit 4 and raises the GPIP interrupt).
// Response channel (rsp_valid, rsp_stall, rsp): one word per request, with
// the read byte and the two interrupt flags.
// Latency: the response is valid the cycle after the request is taken; the
// register state is updated at that same edge.
// Throughput: one request per cycle. The decode and update are a single
// combinational pass into the response register.
// While the response is held by rsp_stall, req_stall is raised; once the
// response is taken a new request is accepted in the same cycle.
// Reset clears the register file, timers and the response valid; the response word itself is not reset.
module multifunction_peripheral_registers_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mfpr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mfpr_pkg::rsp_t rsp
);
  import mfpr_pkg::*;

  logic [7:0]  gpip_value, gpip_value_next;
  logic [7:0]  edge_select, edge_select_next;
  logic [7:0]  pin_direction, pin_direction_next;
  logic [15:0] int_enable, int_enable_next;
  logic [15:0] int_pending, int_pending_next;
  logic [15:0] int_in_service, int_in_service_next;
  logic [15:0] int_mask, int_mask_next;
  logic        auto_end_of_int, auto_end_of_int_next;

  tmr_cmd_t  tcmd [NUM_TIMERS];
  tmr_stat_t tstat [NUM_TIMERS];

  logic        accept;
  logic [31:0] off_full;
  logic [5:0]  off;
  logic        hit;
  logic        do_read;
  logic        do_write;
  logic        ev_tick;
  logic        ev_gpip;
  logic [7:0]  wd;
  rsp_t        rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Decode the window offset
  assign off_full = req.address - MFP_BASE;
  assign hit      = (off_full <= MFP_LAST);
  assign off      = off_full[5:0];
  assign do_read  = accept && (req.op == OP_READ) && hit;
  assign do_write = accept && (req.op == OP_WRITE) && hit;
  assign ev_tick  = accept && (req.op == OP_EVENT) && (req.irq_number == EV_TIMER_C);
  assign ev_gpip  = accept && (req.op == OP_EVENT) && (req.irq_number == EV_GPIP);
  assign wd       = req.write_data;

  // Timer commands
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tcmd[i] = '0;
      tcmd[i].data = wd;
    end
    if (do_write) begin
      unique case (off)
        OFF_TACR: begin
          tcmd[TMR_A].ctrl_we  = 1'b1;
          tcmd[TMR_A].mode     = wd[3:0];
          tcmd[TMR_A].flag_clr = wd[4];
        end
        OFF_TBCR: begin
          tcmd[TMR_B].ctrl_we  = 1'b1;
          tcmd[TMR_B].mode     = wd[3:0];
          tcmd[TMR_B].flag_clr = wd[4];
        end
        OFF_TCDCR: begin
          tcmd[TMR_C].ctrl_we = 1'b1;
          tcmd[TMR_C].mode    = wd[7:4];
          tcmd[TMR_D].ctrl_we = 1'b1;
          tcmd[TMR_D].mode    = wd[3:0];
        end
        OFF_TADR: tcmd[TMR_A].data_we = 1'b1;
        OFF_TBDR: tcmd[TMR_B].data_we = 1'b1;
        OFF_TCDR: tcmd[TMR_C].data_we = 1'b1;
        OFF_TDDR: tcmd[TMR_D].data_we = 1'b1;
        default: ;
      endcase
    end
    if (do_read) begin
      unique case (off)
        OFF_TADR: tcmd[TMR_A].read = 1'b1;
        OFF_TBDR: tcmd[TMR_B].read = 1'b1;
        OFF_TCDR: tcmd[TMR_C].read = 1'b1;
        OFF_TDDR: tcmd[TMR_D].read = 1'b1;
        default: ;
      endcase
    end
    tcmd[TMR_C].tick = ev_tick;
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
    mfpr_timer u_timer (
      .clk  (clk),
      .rst  (rst),
      .cmd  (tcmd[g]),
      .stat (tstat[g])
    );
  end

  // Register writes and GPIP event
  always_comb begin
    gpip_value_next      = gpip_value;
    edge_select_next     = edge_select;
    pin_direction_next   = pin_direction;
    int_enable_next      = int_enable;
    int_pending_next     = int_pending;
    int_in_service_next  = int_in_service;
    int_mask_next        = int_mask;
    auto_end_of_int_next = auto_end_of_int;
    if (do_write) begin
      unique case (off)
        OFF_GPIP:     gpip_value_next = wd;
        OFF_EDGE:     edge_select_next = wd;
        OFF_DIR:      pin_direction_next = wd;
        OFF_IEN_HI:   int_enable_next[15:8] = wd;
        OFF_IEN_LO:   int_enable_next[7:0] = wd;
        OFF_IPEND_HI: int_pending_next[15:8] = wd;
        OFF_IPEND_LO: int_pending_next[7:0] = wd;
        OFF_ISRV_HI:  int_in_service_next[15:8] = wd;
        OFF_ISRV_LO:  int_in_service_next[7:0] = int_in_service[7:0] & wd;
        OFF_IMSK_HI:  int_mask_next[15:8] = wd;
        OFF_IMSK_LO:  int_mask_next[7:0] = wd;
        OFF_VECTOR:   auto_end_of_int_next = wd[3];
        default: ;
      endcase
    end
    if (ev_gpip) begin
      gpip_value_next[4] = 1'b0;
    end
  end

  // Read mux and interrupt flags
  always_comb begin
    rsp_next = '0;
    if (do_read) begin
      unique case (off)
        OFF_GPIP:     rsp_next.read_data = gpip_value & 8'hdf;
        OFF_EDGE:     rsp_next.read_data = edge_select;
        OFF_DIR:      rsp_next.read_data = pin_direction;
        OFF_IEN_HI:   rsp_next.read_data = int_enable[15:8];
        OFF_IEN_LO:   rsp_next.read_data = int_enable[7:0];
        OFF_IPEND_HI: rsp_next.read_data = IPEND_HI_READ;
        OFF_IPEND_LO: rsp_next.read_data = int_pending[7:0];
        OFF_ISRV_HI:  rsp_next.read_data = int_in_service[15:8];
        OFF_ISRV_LO:  rsp_next.read_data = int_in_service[7:0];
        OFF_IMSK_HI:  rsp_next.read_data = int_mask[15:8];
        OFF_IMSK_LO:  rsp_next.read_data = int_mask[7:0];
        OFF_VECTOR:   rsp_next.read_data = auto_end_of_int ? VECTOR_AEOI : VECTOR_BASE;
        OFF_TACR:     rsp_next.read_data = {2'b00, tstat[TMR_A].flag, 1'b0, tstat[TMR_A].mode};
        OFF_TBCR:     rsp_next.read_data = {2'b00, tstat[TMR_B].flag, 1'b0, tstat[TMR_B].mode};
        OFF_TCDCR:    rsp_next.read_data = {tstat[TMR_C].mode, 4'h0}
                                         | {2'b00, tstat[TMR_D].flag, 1'b0, tstat[TMR_D].mode};
        OFF_TADR:     rsp_next.read_data = tstat[TMR_A].count_rd;
        OFF_TBDR:     rsp_next.read_data = tstat[TMR_B].count_rd;
        OFF_TCDR:     rsp_next.read_data = tstat[TMR_C].count_rd;
        OFF_TDDR:     rsp_next.read_data = tstat[TMR_D].count_rd;
        default:      rsp_next.read_data = 8'h00;
      endcase
    end
    rsp_next.timer_irq = tstat[TMR_C].fire;
    rsp_next.gpip_irq  = ev_gpip;
  end

  // Hold register state
  always_ff @(posedge clk) begin
    if (rst) begin
      gpip_value      <= 8'd0;
      edge_select     <= 8'd0;
      pin_direction   <= 8'd0;
      int_enable      <= 16'd0;
      int_pending     <= 16'd0;
      int_in_service  <= 16'd0;
      int_mask        <= 16'd0;
      auto_end_of_int <= 1'b0;
    end else begin
      gpip_value      <= gpip_value_next;
      edge_select     <= edge_select_next;
      pin_direction   <= pin_direction_next;
      int_enable      <= int_enable_next;
      int_pending     <= int_pending_next;
      int_in_service  <= int_in_service_next;
      int_mask        <= int_mask_next;
      auto_end_of_int <= auto_end_of_int_next;
    end
  end

  // Load the response word; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
